>>> rtl/wgm_pkg.sv
// Shared types, constants and helpers for the wildcard name matcher.
// No dependencies; every other file of the block imports it.
package wgm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int PATTERN_STORE_BYTES = 32;   // bytes held by the four pattern words
   localparam int PATTERN_WORDS       = 4;
   localparam int BYTE_W              = 8;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_INDEX_W         = 3;
   localparam int LEN_REG_W           = 6;

   localparam logic [BYTE_W-1:0] CHAR_QUESTION = 8'h3F;
   localparam logic [BYTE_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_LESS     = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_DOT      = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_PAT_LEN   = 3'd4,
      CSR_ICASE     = 3'd5
   } csr_index_type;

   // per-name bookkeeping for the no-extension pattern
   typedef struct packed {
      logic       dot_seen;
      logic       only_dots;
      logic [1:0] len_sat;
   } name_flags_type;

   localparam name_flags_type NAME_FLAGS_START = '{dot_seen: 1'b0, only_dots: 1'b1,
                                                   len_sat: 2'd0};
   localparam logic [1:0] LEN_SAT_MAX = 2'd3;

   // ASCII letter folding, only A-Z move
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic icase);
      logic [BYTE_W-1:0] r;
      r = c;
      if (icase && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

>>> rtl/wgm_if.sv
// Valid/ready channel interfaces for name items and match results.
// Depends on wgm_pkg.
interface wgm_req_if import wgm_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] name_byte;
   logic              empty_name;
   logic              last_byte;

   modport source (output valid, output name_byte, output empty_name, output last_byte,
                   input ready);
   modport sink   (input valid, input name_byte, input empty_name, input last_byte,
                   output ready);
endinterface

interface wgm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

>>> rtl/wildcard_glob_match_core.sv
// Top level of the wildcard name matcher: pattern registers, item pipeline, result stage.
// Depends on wgm_pkg, wgm_if, wgm_closure and wgm_step.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   name_byte[7:0], empty_name, last_byte
//   rsp_chan  out  valid/ready   matched
//   csr_*     in   write enable  csr_index[2:0], csr_wdata[63:0]
//
// One item per cycle sustained, but for the stall below: an item is registered on
// acceptance, and the NFA update (transition plus star-closure prefix network) runs
// from that register straight into the state and result registers.
// Reset (synchronous) clears the pattern and puts the name state at its start.
// An item that ends a name waits in the input register only while the result
// register is full and not being taken; other items pass regardless.
module wildcard_glob_match_core import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   wgm_req_if.sink                req_chan,
   wgm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NPOS = PATTERN_MAX + 1;
   localparam int LW   = $clog2(NPOS);
   localparam int CW   = (LW > LEN_REG_W) ? LW : LEN_REG_W;

   // configuration
   logic [PATTERN_WORDS-1:0][CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [LEN_REG_W-1:0]                     len_ff, len_in;
   logic                                     icase_ff, icase_in;
   logic                                     csr_hit;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic              s1_empty_ff, s1_empty_in;
   logic              s1_last_ff, s1_last_in;

   // name state; fresh means "at start of name", start vector read combinationally
   logic [NPOS-1:0] active_ff, active_in;
   name_flags_type  flags_ff, flags_in;
   logic            fresh_ff, fresh_in;

   // result register
   logic out_valid_ff, out_valid_in;
   logic matched_ff, matched_in;

   logic                               accept;
   logic                               s1_term;
   logic                               s1_fire;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes;
   logic [PATTERN_MAX-1:0]             live;
   logic [PATTERN_MAX-1:0]             star_mask;
   logic [CW-1:0]                      len_ext;
   logic [LW-1:0]                      eff_len;
   logic                               special;
   logic [NPOS-1:0]                    start_vec;
   logic [NPOS-1:0]                    step_vec;
   logic [NPOS-1:0]                    cur_active;
   logic [NPOS-1:0]                    next_active;
   name_flags_type                     cur_flags;
   name_flags_type                     next_flags;
   logic                               result;

   // ---- pattern view ----
   // pattern_length above PATTERN_MAX clamps; bytes past the stored 32 read as NUL
   assign len_ext = CW'(len_ff);
   assign eff_len = (len_ext > CW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_ext);

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
      if (i < PATTERN_STORE_BYTES) begin : g_stored
         assign pat_bytes[i] = pat_ff[i / 8][(i % 8) * BYTE_W +: BYTE_W];
      end else begin : g_blank
         assign pat_bytes[i] = '0;
      end
      assign live[i]      = LW'(i) < eff_len;
      assign star_mask[i] = live[i] && (pat_bytes[i] == CHAR_STAR);
   end

   // "<" with case folding: no-extension names, plus "." and ".."
   assign special = icase_ff && (eff_len == LW'(1)) && (pat_bytes[0] == CHAR_LESS);

   // start state: position 0 plus whatever stars lead on from it
   wgm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_start_closure (
      .seed      (NPOS'(1)),
      .star_mask (star_mask),
      .closed    (start_vec)
   );

   // ---- handshake ----
   assign accept  = req_chan.valid && req_chan.ready;
   assign s1_term = s1_empty_ff || s1_last_ff;
   assign s1_fire = s1_valid_ff && (!s1_term || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;

   // ---- NFA update ----
   assign cur_active = fresh_ff ? start_vec : active_ff;
   assign cur_flags  = fresh_ff ? NAME_FLAGS_START : flags_ff;

   wgm_step #(.PATTERN_MAX(PATTERN_MAX)) u_step (
      .cur_active  (cur_active),
      .live        (live),
      .star_mask   (star_mask),
      .pat_bytes   (pat_bytes),
      .name_byte   (s1_byte_ff),
      .icase       (icase_ff),
      .next_active (step_vec)
   );

   always_comb begin
      next_active = cur_active;
      next_flags  = cur_flags;
      if (!s1_empty_ff) begin
         next_active = step_vec;
         if (s1_byte_ff == CHAR_DOT) begin
            next_flags.dot_seen = 1'b1;
         end else begin
            next_flags.only_dots = 1'b0;
         end
         if (cur_flags.len_sat != LEN_SAT_MAX) begin
            next_flags.len_sat = cur_flags.len_sat + 2'd1;
         end
      end
   end

   always_comb begin
      if (special) begin
         result = !next_flags.dot_seen ||
                  (next_flags.only_dots && (next_flags.len_sat != 2'd0) &&
                   (next_flags.len_sat != LEN_SAT_MAX));
      end else begin
         result = next_active[eff_len];
      end
   end

   // ---- register write decode ----
   always_comb begin
      pat_in   = pat_ff;
      len_in   = len_ff;
      icase_in = icase_ff;
      csr_hit  = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index)) inside
            CSR_PAT_0_7, CSR_PAT_8_15, CSR_PAT_16_23, CSR_PAT_24_31: begin
               pat_in[csr_index[1:0]] = csr_wdata;
               csr_hit = 1'b1;
            end
            CSR_PAT_LEN: begin
               len_in  = csr_wdata[LEN_REG_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_ICASE: begin
               icase_in = csr_wdata[0];
               csr_hit  = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;   // unmapped index, ignored
            end
         endcase
      end
   end

   // ---- next state ----
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_empty_in = s1_empty_ff;
      s1_last_in  = s1_last_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_chan.name_byte;
         s1_empty_in = req_chan.empty_name;
         s1_last_in  = req_chan.last_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      active_in = active_ff;
      flags_in  = flags_ff;
      fresh_in  = fresh_ff;
      if (s1_fire) begin
         active_in = next_active;
         flags_in  = next_flags;
         fresh_in  = s1_term;   // name ends: restart from the start state
      end
      if (csr_hit) begin
         fresh_in = 1'b1;
      end

      out_valid_in = out_valid_ff;
      matched_in   = matched_ff;
      if (s1_fire && s1_term) begin
         out_valid_in = 1'b1;
         matched_in   = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         len_ff       <= '0;
         icase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         flags_ff     <= NAME_FLAGS_START;
         fresh_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         len_ff       <= len_in;
         icase_ff     <= icase_in;
         s1_valid_ff  <= s1_valid_in;
         flags_ff     <= flags_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_empty_ff <= s1_empty_in;
      s1_last_ff  <= s1_last_in;
      active_ff   <= active_in;
      matched_ff  <= matched_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.matched = matched_ff;

endmodule

>>> rtl/wgm_closure.sv
// Star closure over pattern positions as a log-depth prefix network.
// Depends on wgm_pkg.
module wgm_closure import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic [PATTERN_MAX:0]   seed,
   input  logic [PATTERN_MAX-1:0] star_mask,   // live star at each position
   output logic [PATTERN_MAX:0]   closed
);

   localparam int NPOS   = PATTERN_MAX + 1;
   localparam int LEVELS = (NPOS > 1) ? $clog2(NPOS) : 1;

   logic [NPOS-1:0] g_lvl [LEVELS+1];
   logic [NPOS-1:0] p_lvl [LEVELS+1];

   // position j inherits from j-1 when j-1 is a live star
   always_comb begin
      g_lvl[0] = seed;
      p_lvl[0] = {star_mask, 1'b0};
      for (int d = 0; d < LEVELS; d++) begin
         for (int j = 0; j < NPOS; j++) begin
            if (j >= (1 << d)) begin
               g_lvl[d+1][j] = g_lvl[d][j] | (p_lvl[d][j] & g_lvl[d][j - (1 << d)]);
               p_lvl[d+1][j] = p_lvl[d][j] & p_lvl[d][j - (1 << d)];
            end else begin
               g_lvl[d+1][j] = g_lvl[d][j];
               p_lvl[d+1][j] = 1'b0;
            end
         end
      end
   end

   assign closed = g_lvl[LEVELS];

endmodule

>>> rtl/wgm_step.sv
// One name byte through the position NFA: transitions then star closure.
// Depends on wgm_pkg and wgm_closure.
module wgm_step import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic [PATTERN_MAX:0]               cur_active,
   input  logic [PATTERN_MAX-1:0]             live,
   input  logic [PATTERN_MAX-1:0]             star_mask,
   input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes,
   input  logic [BYTE_W-1:0]                  name_byte,
   input  logic                               icase,
   output logic [PATTERN_MAX:0]               next_active
);

   logic [PATTERN_MAX:0]   seed;
   logic [PATTERN_MAX-1:0] hit;
   logic [BYTE_W-1:0]      name_folded;

   assign name_folded = fold_byte(name_byte, icase);

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         hit[i] = (pat_bytes[i] == CHAR_QUESTION) ||
                  (fold_byte(pat_bytes[i], icase) == name_folded);
      end
   end

   // a star keeps its position, anything else that hits moves one on
   always_comb begin
      seed = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (cur_active[i] && live[i]) begin
            if (star_mask[i]) begin
               seed[i] = 1'b1;
            end else if (hit[i]) begin
               seed[i+1] = 1'b1;
            end
         end
      end
   end

   wgm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_closure (
      .seed      (seed),
      .star_mask (star_mask),
      .closed    (next_active)
   );

endmodule

>>> test/wgm_match_checker.sv
// Match checker for the wildcard name matcher: mirrors the pattern registers,
// predicts the match result of every name and compares it with the block's output.
// Depends on wgm_pkg and the channel interfaces in wgm_if.
`timescale 1ns / 1ps
module wgm_match_checker import wgm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   wgm_req_if                     req_mon,
   wgm_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     matches_pending
);

   localparam int NPOS = PATTERN_MAX_DEFAULT + 1;

   logic [CSR_DATA_W-1:0] pat_word [PATTERN_WORDS];
   logic [LEN_REG_W-1:0]  pat_len_reg;
   logic                  fold_case;
   logic [NPOS-1:0]       live_pos;
   name_flags_type        flags;
   logic                  match_expected_q [$];

   function automatic int used_len();
      return (pat_len_reg > PATTERN_MAX_DEFAULT) ? PATTERN_MAX_DEFAULT : int'(pat_len_reg);
   endfunction

   function automatic logic [BYTE_W-1:0] pat_at(input int i);
      if (i >= PATTERN_STORE_BYTES) begin
         return '0;
      end
      return pat_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic logic [BYTE_W-1:0] lower_letter(input logic [BYTE_W-1:0] c);
      if (fold_case && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c | CASE_OFFSET;
      end
      return c;
   endfunction

   // a live star also makes the position after it live
   function automatic logic [NPOS-1:0] close_stars(input logic [NPOS-1:0] v);
      logic [NPOS-1:0] r;
      r = v;
      for (int i = 0; i < used_len(); i++) begin
         if (r[i] && pat_at(i) == CHAR_STAR) begin
            r[i+1] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void restart_name();
      live_pos = close_stars(NPOS'(1));
      flags    = NAME_FLAGS_START;
   endfunction

   function automatic void take_byte(input logic [BYTE_W-1:0] c);
      logic [NPOS-1:0]   nxt;
      logic [BYTE_W-1:0] p;
      nxt = '0;
      for (int i = 0; i < used_len(); i++) begin
         if (live_pos[i]) begin
            p = pat_at(i);
            if (p == CHAR_STAR) begin
               nxt[i] = 1'b1;
            end else if (p == CHAR_QUESTION || lower_letter(p) == lower_letter(c)) begin
               nxt[i+1] = 1'b1;
            end
         end
      end
      live_pos = close_stars(nxt);
      if (c == CHAR_DOT) begin
         flags.dot_seen = 1'b1;
      end else begin
         flags.only_dots = 1'b0;
      end
      if (flags.len_sat != LEN_SAT_MAX) begin
         flags.len_sat = flags.len_sat + 2'd1;
      end
   endfunction

   // "<" with case folding: no dot at all, or one or two dots and nothing else
   function automatic logic name_verdict();
      if (fold_case && used_len() == 1 && pat_at(0) == CHAR_LESS) begin
         return !flags.dot_seen ||
                (flags.only_dots && flags.len_sat >= 2'd1 && flags.len_sat <= 2'd2);
      end
      return live_pos[used_len()];
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         foreach (pat_word[w]) pat_word[w] = '0;
         pat_len_reg = '0;
         fold_case   = 1'b0;
         restart_name();
         match_expected_q.delete();
      end else begin
         if (csr_we && csr_index <= CSR_ICASE) begin
            case (csr_index)
               CSR_PAT_LEN: pat_len_reg = csr_wdata[LEN_REG_W-1:0];
               CSR_ICASE:   fold_case = csr_wdata[0];
               default:     pat_word[csr_index[1:0]] = csr_wdata;
            endcase
            restart_name();
         end
         if (req_mon.valid && req_mon.ready) begin
            if (!req_mon.empty_name) begin
               take_byte(req_mon.name_byte);
            end
            if (req_mon.empty_name || req_mon.last_byte) begin
               match_expected_q.push_back(name_verdict());
               restart_name();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (match_expected_q.size() == 0) begin
               $error("matched: expected no result, actual %0b", rsp_mon.matched);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = match_expected_q.pop_front();
               if (rsp_mon.matched !== want) begin
                  $error("matched: expected %0b, actual %0b", want, rsp_mon.matched);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      matches_pending <= match_expected_q.size();
   end

endmodule

>>> test/tb_wildcard_glob_match_core.sv
// Testbench top for wildcard_glob_match_core: drives pattern registers and name items,
// idles both channels at random and gives the verdict from the match checker's count.
// Depends on wgm_pkg, wgm_if, the block itself and wgm_match_checker.
`timescale 1ns / 1ps
module tb_wildcard_glob_match_core;
   import wgm_pkg::*;

   localparam int MAX_GAP       = 6;
   localparam int TOTAL_ITEMS   = 1750;
   localparam int HOLD_CYCLES   = 150;     // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES = 4;       // input register plus state update, with margin
   localparam int CYCLE_LIMIT   = 400000;

   // indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG_B = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int matches_pending;
   int items_sent  = 0;
   int cycle_count = 0;

   // per-phase idling switches and the one-off hold-off request
   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   bit rsp_hold_req = 1'b0;

   // pattern as it is about to be programmed, and the name being built
   logic [BYTE_W-1:0]    pat_b [PATTERN_STORE_BYTES];
   logic [LEN_REG_W-1:0] pat_len;
   logic                 pat_icase;
   logic [BYTE_W-1:0]    name_q [$];

   wgm_req_if req_if ();
   wgm_rsp_if rsp_if ();

   wildcard_glob_match_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wgm_match_checker u_match_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .matches_pending (matches_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly letters around the case boundaries and dots, now and then any byte.
   function automatic logic [BYTE_W-1:0] random_char();
      case ($urandom_range(0, 8))
         0:       return "a";
         1:       return "b";
         2:       return "A";
         3:       return "B";
         4:       return CHAR_DOT;
         5:       return "z";
         6:       return "[";    // just past 'Z', must not fold
         7:       return "@";    // just before 'A'
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds the next name. Most names follow the pattern (stars get a random run,
   // '?' any byte, letters may flip case), some get one byte spoilt; the rest are
   // random text, dot-only names and raw bytes.
   function automatic void build_name();
      int                kind;
      int                eff;
      logic [BYTE_W-1:0] c;
      name_q.delete();
      eff  = (pat_len > PATTERN_STORE_BYTES) ? PATTERN_STORE_BYTES : int'(pat_len);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         for (int i = 0; i < eff; i++) begin
            c = pat_b[i];
            if (c == CHAR_STAR) begin
               repeat ($urandom_range(0, 3)) name_q.push_back(random_char());
            end else if (c == CHAR_QUESTION) begin
               name_q.push_back(random_char());
            end else begin
               if (((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= "a" && c <= "z"))
                   && $urandom_range(0, 1)) begin
                  c = c ^ CASE_OFFSET;
               end
               name_q.push_back(c);
            end
         end
         if ($urandom_range(0, 4) == 0 && name_q.size() > 0) begin
            name_q[$urandom_range(0, name_q.size() - 1)] = random_char();
         end
      end else if (kind < 8) begin
         repeat ($urandom_range(0, 8)) name_q.push_back(random_char());
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 3)) name_q.push_back(CHAR_DOT);
      end else begin
         repeat ($urandom_range(0, 6)) name_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // One item on the request channel; returns after the edge that takes it.
   // valid stays high between back-to-back items.
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic e, input logic l);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.name_byte  <= b;
      req_if.empty_name <= e;
      req_if.last_byte  <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // Streams name_q. An empty name is a single empty item; with trail_empty the
   // name is closed by an empty item instead of last_byte on its final byte.
   task automatic send_name(input bit trail_empty);
      if (name_q.size() == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
      end else begin
         foreach (name_q[i]) begin
            send_item(name_q[i], 1'b0, (i == name_q.size() - 1) && !trail_empty);
         end
         if (trail_empty) begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Leaves csr_we high; the caller lowers it after its last write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all six registers from pat_b/pat_len/pat_icase. Upper bits of the
   // narrow registers carry noise, which the block must drop.
   task automatic program_pattern(input bit stray);
      logic [CSR_DATA_W-1:0] word;
      for (int w = 0; w < PATTERN_WORDS; w++) begin
         for (int j = 0; j < 8; j++) word[j*8 +: 8] = pat_b[w*8 + j];
         csr_write(CSR_INDEX_W'(w), word);
      end
      word = {$urandom, $urandom};
      word[LEN_REG_W-1:0] = pat_len;
      csr_write(CSR_PAT_LEN, word);
      word = {$urandom, $urandom};
      word[0] = pat_icase;
      csr_write(CSR_ICASE, word);
      if (stray) begin
         csr_write($urandom_range(0, 1) ? CSR_NO_REG_A : CSR_NO_REG_B, {$urandom, $urandom});
      end
      csr_we <= 1'b0;
   endtask

   // Stops offering, waits for every outstanding result, then lets any item that
   // gives no result drain out of the block. The first edge lets the checker
   // count an item taken at the current edge.
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (matches_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls per item, one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_hold_req) begin
            stall        = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      int n_names;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_PAT_0_7;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.name_byte  <= '0;
      req_if.empty_name <= 1'b0;
      req_if.last_byte  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // after reset the pattern is empty: only an empty name matches
      name_q = {};
      send_item(8'hA5, 1'b1, 1'b0);          // empty item ends the name without last_byte
      name_q = '{"a"};
      send_name(1'b0);
      wait_quiet();

      // "A**" plus a zero byte, case folded: runs of stars, zero byte as a literal
      foreach (pat_b[i]) pat_b[i] = 8'h00;
      pat_b[0] = "A";
      pat_b[1] = CHAR_STAR;
      pat_b[2] = CHAR_STAR;
      pat_b[3] = 8'h00;
      pat_len   = 6'd4;
      pat_icase = 1'b1;
      program_pattern(1'b0);
      name_q = '{"a", 8'h00};
      send_name(1'b0);
      name_q = '{"a", 8'hFF, "Z", 8'h00};
      send_name(1'b0);
      name_q = '{"a"};
      send_name(1'b1);                       // closed by an empty item mid-stream
      wait_quiet();

      // length register far past the store is clamped; stray register writes
      foreach (pat_b[i]) pat_b[i] = 8'hFF;
      pat_b[0]  = CHAR_STAR;
      pat_len   = 6'd63;
      pat_icase = 1'b0;
      program_pattern(1'b1);
      name_q = '{8'h00};
      send_name(1'b0);
      name_q = '{8'hFF};
      send_name(1'b0);
      wait_quiet();

      // no-extension pattern "<" with case folding
      foreach (pat_b[i]) pat_b[i] = 8'h00;
      pat_b[0]  = CHAR_LESS;
      pat_len   = 6'd1;
      pat_icase = 1'b1;
      program_pattern(1'b0);
      name_q = '{"a", "b"};
      send_name(1'b0);
      name_q = '{"a", CHAR_DOT, "b"};
      send_name(1'b0);
      name_q = '{CHAR_DOT};
      send_name(1'b0);
      name_q = '{CHAR_DOT, CHAR_DOT};
      send_name(1'b0);
      name_q = '{CHAR_DOT, CHAR_DOT, CHAR_DOT};
      send_name(1'b0);

      // register write with a name half streamed: the name restarts
      send_item("q", 1'b0, 1'b0);
      wait_quiet();
      csr_write(CSR_ICASE, {{(CSR_DATA_W-1){1'b0}}, 1'b1});
      csr_we <= 1'b0;
      name_q = '{"x", CHAR_DOT};
      send_name(1'b0);
      wait_quiet();

      // --- random part, in phases of one pattern each ---
      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         phase++;
         foreach (pat_b[i]) pat_b[i] = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 19))
            0:       pat_len = 6'd0;
            1:       pat_len = 6'(PATTERN_STORE_BYTES);
            2:       pat_len = 6'($urandom_range(33, 63));
            3, 4, 5: pat_len = 6'($urandom_range(9, 31));
            default: pat_len = 6'($urandom_range(1, 8));
         endcase
         for (int i = 0; i < PATTERN_STORE_BYTES; i++) begin
            if (i < pat_len) begin
               case ($urandom_range(0, 9))
                  0, 1:    pat_b[i] = CHAR_STAR;
                  2:       pat_b[i] = CHAR_QUESTION;
                  default: pat_b[i] = random_char();
               endcase
            end
         end
         pat_icase = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) begin
            pat_b[0]  = CHAR_LESS;
            pat_len   = 6'd1;
            pat_icase = $urandom_range(0, 3) != 0;
         end
         program_pattern($urandom_range(0, 5) == 0);

         // some phases run without idling at all
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         if (phase == 2) begin
            // sender keeps offering while the receiver holds off
            req_idle_on  = 1'b0;
            rsp_hold_req = 1'b1;
         end

         n_names = $urandom_range(20, 50);
         for (int k = 0; k < n_names && items_sent < TOTAL_ITEMS; k++) begin
            build_name();
            send_name($urandom_range(0, 5) == 0);
            if (phase % 5 == 0 && k == n_names / 2) begin
               wait_quiet();                  // sender pauses until all results are in
            end
         end
         wait_quiet();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
